// ===== sv/psc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants of the statement classifier
// Token kind codes, statement type codes, phase encoding, the fixed prefix
// table and the request/result payload structs.
// ----------------------------------------------------------------------------
package psc_pkg;

  typedef logic [5:0] kind_t;
  typedef logic [3:0] stmt_t;

  // Request opcodes
  localparam logic OP_TOKEN = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Token kinds used by the classifier
  localparam kind_t etOTHER     = 6'd0;
  localparam kind_t etDECLARE   = 6'd1;
  localparam kind_t etFUNCTION  = 6'd2;
  localparam kind_t etPROCEDURE = 6'd3;
  localparam kind_t etPACKAGE   = 6'd4;
  localparam kind_t etBODY      = 6'd5;
  localparam kind_t etBEGIN     = 6'd6;
  localparam kind_t etSEMICOLON = 6'd19;
  localparam kind_t etSLASH     = 6'd25;
  localparam kind_t etCREATE    = 6'd33;
  localparam kind_t etLESS      = 6'd40;
  localparam kind_t etTRIGGER   = 6'd42;
  localparam kind_t etTYPE      = 6'd43;
  localparam kind_t etOR        = 6'd44;
  localparam kind_t etREPLACE   = 6'd45;
  localparam kind_t etDOT       = 6'd46;
  localparam kind_t etCOLON     = 6'd47;
  localparam kind_t etEQUAL     = 6'd48;
  localparam kind_t etEOL       = 6'd49;
  localparam kind_t etEOF       = 6'd50;
  localparam kind_t etCOMMENT   = 6'd51;

  // Statement types
  localparam stmt_t ST_SQL       = 4'd0;
  localparam stmt_t ST_BLOCK     = 4'd1;
  localparam stmt_t ST_FUNCTION  = 4'd2;
  localparam stmt_t ST_PROCEDURE = 4'd3;
  localparam stmt_t ST_PACKAGE   = 4'd4;
  localparam stmt_t ST_PKG_BODY  = 4'd5;
  localparam stmt_t ST_TRIGGER   = 4'd6;
  localparam stmt_t ST_TYPE      = 4'd7;
  localparam stmt_t ST_TYPE_BODY = 4'd8;

  // Recognition phase
  typedef enum logic [3:0] {
    PH_TYPE    = 4'b0001,
    PH_NAME    = 4'b0010,
    PH_PENDING = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  localparam logic [1:0] PHC_TYPE    = 2'd0;
  localparam logic [1:0] PHC_NAME    = 2'd1;
  localparam logic [1:0] PHC_PENDING = 2'd2;
  localparam logic [1:0] PHC_DONE    = 2'd3;

  // Prefix table
  localparam int NUM_ROWS = 17;
  localparam int ROW_MAX  = 5;

  typedef logic [NUM_ROWS-1:0] row_vec_t;

  localparam stmt_t ROW_TYPE [NUM_ROWS] = '{
    ST_BLOCK, ST_BLOCK, ST_BLOCK,
    ST_FUNCTION, ST_PKG_BODY, ST_PACKAGE, ST_PROCEDURE, ST_TRIGGER,
    ST_TYPE_BODY, ST_TYPE,
    ST_FUNCTION, ST_PKG_BODY, ST_PACKAGE, ST_PROCEDURE, ST_TRIGGER,
    ST_TYPE_BODY, ST_TYPE
  };

  localparam logic [2:0] ROW_LEN [NUM_ROWS] = '{
    3'd2, 3'd1, 3'd1,
    3'd2, 3'd3, 3'd2, 3'd2, 3'd2, 3'd3, 3'd2,
    3'd4, 3'd5, 3'd4, 3'd4, 3'd4, 3'd5, 3'd4
  };

  localparam kind_t ROW_SEQ [NUM_ROWS][ROW_MAX] = '{
    '{etLESS,    etLESS,      etOTHER,     etOTHER,     etOTHER},
    '{etDECLARE, etOTHER,     etOTHER,     etOTHER,     etOTHER},
    '{etBEGIN,   etOTHER,     etOTHER,     etOTHER,     etOTHER},
    '{etCREATE,  etFUNCTION,  etOTHER,     etOTHER,     etOTHER},
    '{etCREATE,  etPACKAGE,   etBODY,      etOTHER,     etOTHER},
    '{etCREATE,  etPACKAGE,   etOTHER,     etOTHER,     etOTHER},
    '{etCREATE,  etPROCEDURE, etOTHER,     etOTHER,     etOTHER},
    '{etCREATE,  etTRIGGER,   etOTHER,     etOTHER,     etOTHER},
    '{etCREATE,  etTYPE,      etBODY,      etOTHER,     etOTHER},
    '{etCREATE,  etTYPE,      etOTHER,     etOTHER,     etOTHER},
    '{etCREATE,  etOR,        etREPLACE,   etFUNCTION,  etOTHER},
    '{etCREATE,  etOR,        etREPLACE,   etPACKAGE,   etBODY},
    '{etCREATE,  etOR,        etREPLACE,   etPACKAGE,   etOTHER},
    '{etCREATE,  etOR,        etREPLACE,   etPROCEDURE, etOTHER},
    '{etCREATE,  etOR,        etREPLACE,   etTRIGGER,   etOTHER},
    '{etCREATE,  etOR,        etREPLACE,   etTYPE,      etBODY},
    '{etCREATE,  etOR,        etREPLACE,   etTYPE,      etOTHER}
  };

  // Matcher status toward the control logic
  typedef struct packed {
    row_vec_t alive;      // rows still matching after appending the token
    logic     extend;     // token extends some row
    logic     old_exact;  // current store equals a whole row
    stmt_t    old_type;   // type of the first such row
  } psc_match_t;

  // Request payload
  typedef struct packed {
    logic       op;
    kind_t      token_kind;
    logic       at_column_zero;
    logic [15:0] token_ref;
  } psc_in_t;

  // Result payload
  typedef struct packed {
    logic [1:0]  phase;
    stmt_t       statement_type;
    logic        is_bind_var;
    logic        name_valid;
    logic [15:0] name_ref;
    logic        owner_valid;
    logic [15:0] owner_ref;
    logic        needs_semicolon;
    logic        may_have_errors;
    logic [15:0] error_base_ref;
  } psc_out_t;

  function automatic logic [1:0] phase_code(phase_t p);
    logic [1:0] c;
    case (p)
      PH_TYPE:    c = PHC_TYPE;
      PH_NAME:    c = PHC_NAME;
      PH_PENDING: c = PHC_PENDING;
      PH_DONE:    c = PHC_DONE;
      default:    c = PHC_TYPE;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/plsql_statement_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsql_statement_classifier: token-stream statement classifier
// Classifies one SQL / PL/SQL statement from lexer tokens and tracks its
// object name and completion.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall with an in_data payload; op clear
//   restarts recognition, op token presents one lexer token. Every request
//   gives exactly one result on out_valid/out_stall, showing the state after
//   that request.
//   From acceptance, a request passes through the input register, then the
//   classifier update and the result register. Throughput is one request
//   per cycle while out_stall is low; the prefix table is compared in
//   parallel in the single update stage, so the compare holds no request back.
//   While out_stall holds, the result register keeps its result and one
//   more request can sit in the input register; after that in_stall rises.
//   Synchronous reset (rst_n low) empties both registers and puts the
//   classifier in type recognition with an empty prefix and no names.
// ----------------------------------------------------------------------------
module plsql_statement_classifier
  import psc_pkg::*;
#(
  parameter int PREFIX_DEPTH = 6
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  psc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output psc_out_t out_data
);

  localparam int CNT_W = $clog2(PREFIX_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PREFIX_DEPTH);

  // Pipeline registers
  logic     in_v_r, in_v_nxt;
  psc_in_t  in_item_r;
  logic     out_v_r, out_v_nxt;
  psc_out_t out_item_r, out_item_nxt;
  logic     adv;

  // Classifier state
  phase_t           phase_r, phase_nxt;
  stmt_t            stype_r, stype_nxt;
  row_vec_t         alive_r, alive_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  kind_t            last_kind_r, last_kind_nxt;
  logic [15:0]      last_ref_r, last_ref_nxt;
  logic [15:0]      prev_ref_r, prev_ref_nxt;
  logic             first_v_r, first_v_nxt;
  logic [15:0]      first_ref_r, first_ref_nxt;
  logic             second_v_r, second_v_nxt;
  logic [15:0]      second_ref_r, second_ref_nxt;
  kind_t            prev_kind_r, prev_kind_nxt;

  psc_match_t match;
  logic       bind_hit;

  // Stage handshake
  assign adv       = in_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_v_r && !adv;
  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

  assign in_v_nxt  = (in_valid && !in_stall) ? 1'b1 : (adv ? 1'b0 : in_v_r);
  assign out_v_nxt = adv ? 1'b1 : (out_stall ? out_v_r : 1'b0);

  psc_prefix_match #(
    .CNT_W (CNT_W)
  ) u_match (
    .alive (alive_r),
    .count (count_r),
    .kind  (in_item_r.token_kind),
    .res   (match)
  );

  // Classifier update for the request in the input register
  always_comb begin
    kind_t       kind;
    logic [15:0] ref_tag;
    logic        do_name;
    logic        do_push;
    logic        slash0;

    kind     = in_item_r.token_kind;
    ref_tag  = in_item_r.token_ref;
    do_name  = 1'b0;
    do_push  = 1'b0;
    slash0   = (kind == etSLASH) && in_item_r.at_column_zero;
    bind_hit = 1'b0;

    phase_nxt      = phase_r;
    stype_nxt      = stype_r;
    alive_nxt      = alive_r;
    count_nxt      = count_r;
    last_kind_nxt  = last_kind_r;
    last_ref_nxt   = last_ref_r;
    prev_ref_nxt   = prev_ref_r;
    first_v_nxt    = first_v_r;
    first_ref_nxt  = first_ref_r;
    second_v_nxt   = second_v_r;
    second_ref_nxt = second_ref_r;
    prev_kind_nxt  = prev_kind_r;

    if (in_item_r.op == OP_CLEAR) begin
      phase_nxt     = PH_TYPE;
      stype_nxt     = ST_SQL;
      alive_nxt     = '1;
      count_nxt     = '0;
      first_v_nxt   = 1'b0;
      second_v_nxt  = 1'b0;
      prev_kind_nxt = etOTHER;
    end else if (kind != etCOMMENT) begin
      case (phase_r)
        PH_TYPE: begin
          if (kind != etEOL) begin
            if (count_r < CNT_FULL && match.extend) begin
              do_push   = 1'b1;
              alive_nxt = match.alive;
            end else if (match.old_exact) begin
              stype_nxt = match.old_type;
              phase_nxt = PH_NAME;
              do_name   = 1'b1;
            end else begin
              phase_nxt = PH_PENDING;
            end
          end
        end
        PH_NAME: begin
          do_name = 1'b1;
        end
        PH_PENDING: begin
          if (stype_r == ST_SQL) begin
            if (kind == etSEMICOLON || slash0) begin
              phase_nxt = PH_DONE;
            end
          end else begin
            // trigger body start joins the stored prefix
            if (stype_r == ST_TRIGGER && count_r != '0 && count_r < CNT_FULL &&
                last_kind_r == etTRIGGER && (kind == etDECLARE || kind == etBEGIN)) begin
              do_push = 1'b1;
            end
            if (kind == etEOF || slash0) begin
              phase_nxt = PH_DONE;
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      if (do_push) begin
        count_nxt     = count_r + CNT_W'(1);
        prev_ref_nxt  = last_ref_r;
        last_ref_nxt  = ref_tag;
        last_kind_nxt = kind;
      end

      // owner.name capture
      if (do_name) begin
        if (!first_v_r) begin
          first_v_nxt   = 1'b1;
          first_ref_nxt = ref_tag;
        end else if (kind != etDOT && prev_kind_r == etDOT) begin
          second_v_nxt   = 1'b1;
          second_ref_nxt = ref_tag;
        end else if (kind != etDOT) begin
          phase_nxt = PH_PENDING;
        end
      end

      bind_hit      = (prev_kind_r == etCOLON) && (kind != etEQUAL);
      prev_kind_nxt = kind;
    end
  end

  // Result fields from the updated state
  always_comb begin
    out_item_nxt                 = '0;
    out_item_nxt.phase           = phase_code(phase_nxt);
    out_item_nxt.statement_type  = stype_nxt;
    out_item_nxt.is_bind_var     = bind_hit;
    if (second_v_nxt) begin
      out_item_nxt.owner_valid = 1'b1;
      out_item_nxt.owner_ref   = first_ref_nxt;
      out_item_nxt.name_valid  = 1'b1;
      out_item_nxt.name_ref    = second_ref_nxt;
    end else if (first_v_nxt) begin
      out_item_nxt.name_valid = 1'b1;
      out_item_nxt.name_ref   = first_ref_nxt;
    end
    out_item_nxt.needs_semicolon = (stype_nxt != ST_SQL);
    out_item_nxt.may_have_errors = (stype_nxt != ST_SQL) && (stype_nxt != ST_BLOCK);
    // last stored token, stepping back over a trailing BODY
    if (count_nxt != '0) begin
      if (last_kind_nxt == etBODY) begin
        if (count_nxt > CNT_W'(1)) begin
          out_item_nxt.error_base_ref = prev_ref_nxt;
        end
      end else begin
        out_item_nxt.error_base_ref = last_ref_nxt;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      phase_r      <= PH_TYPE;
      stype_r      <= ST_SQL;
      alive_r      <= '1;
      count_r      <= '0;
      first_v_r    <= 1'b0;
      second_v_r   <= 1'b0;
      prev_kind_r  <= etOTHER;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      if (adv) begin
        phase_r     <= phase_nxt;
        stype_r     <= stype_nxt;
        alive_r     <= alive_nxt;
        count_r     <= count_nxt;
        first_v_r   <= first_v_nxt;
        second_v_r  <= second_v_nxt;
        prev_kind_r <= prev_kind_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
    if (adv) begin
      out_item_r   <= out_item_nxt;
      last_kind_r  <= last_kind_nxt;
      last_ref_r   <= last_ref_nxt;
      prev_ref_r   <= prev_ref_nxt;
      first_ref_r  <= first_ref_nxt;
      second_ref_r <= second_ref_nxt;
    end
  end

endmodule

// ===== sv/psc_prefix_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_prefix_match: parallel prefix table compare
// Keeps one live bit per table row; a new token at position count narrows
// the live set. Also reports the first row that the current store equals.
// ----------------------------------------------------------------------------
module psc_prefix_match
  import psc_pkg::*;
#(
  parameter int CNT_W = 3
) (
  input  row_vec_t         alive,
  input  logic [CNT_W-1:0] count,
  input  kind_t            kind,
  output psc_match_t       res
);

  row_vec_t alive_nxt;
  logic     old_exact;
  stmt_t    old_type;

  // Narrow the live rows by the token at the next position
  always_comb begin
    logic pos_hit;
    for (int r = 0; r < NUM_ROWS; r++) begin
      pos_hit = 1'b0;
      for (int j = 0; j < ROW_MAX; j++) begin
        if (count == CNT_W'(j) && ROW_SEQ[r][j] == kind) begin
          pos_hit = 1'b1;
        end
      end
      alive_nxt[r] = alive[r] && (CNT_W'(ROW_LEN[r]) > count) && pos_hit;
    end
  end

  // Exact match on the current store, first row in table order wins
  always_comb begin
    old_exact = 1'b0;
    old_type  = ST_SQL;
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      if (alive[r] && CNT_W'(ROW_LEN[r]) == count) begin
        old_exact = 1'b1;
        old_type  = ROW_TYPE[r];
      end
    end
  end

  assign res.alive     = alive_nxt;
  assign res.extend    = |alive_nxt;
  assign res.old_exact = old_exact;
  assign res.old_type  = old_type;

endmodule
